@@ hw/rtl/acgm_pkg.sv @@
// ----------------------------------------------------------------------------
// acgm_pkg
// Shared types and constants of the stereo clip gain mixer: beat payloads,
// opcodes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package acgm_pkg;

  // default sizes of the mix store
  localparam int MixFramesDef = 16384;
  localparam int AccWidthDef  = 32;

  // item opcodes
  localparam logic [1:0] OpBegin = 2'd0;
  localparam logic [1:0] OpClip  = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  // configuration port sizes and register indexes
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 25;

  localparam logic [CfgIdxW-1:0] RegGain        = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartFrame  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegClipStart   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxFrames   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTotalFrames = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMonoSource  = 3'd5;

  // register reset values
  localparam logic [15:0]        GainRst        = 16'd4096;
  localparam logic [14:0]        StartFrameRst  = 15'd0;
  localparam logic [23:0]        ClipStartRst   = 24'd0;
  localparam logic signed [24:0] MaxFramesRst   = -25'sd1;
  localparam logic [14:0]        TotalFramesRst = 15'd16384;
  localparam logic               MonoSourceRst  = 1'b0;

  // input beat
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [13:0]        frame_index;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic signed [15:0] pcm_left;
    logic signed [15:0] pcm_right;
  } out_item_t;

endpackage

@@ hw/rtl/acgm_ram.sv @@
// ----------------------------------------------------------------------------
// acgm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module acgm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/audio_clip_gain_mixer_top.sv @@
// ----------------------------------------------------------------------------
// audio_clip_gain_mixer_top
// Stereo clip mixer: scales clip frames by a Q4.12 gain into a store of
// saturating Q17.15 accumulators and reads frames back as rounded PCM16.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | sink      | in_valid_i/in_stall_o | acgm_pkg::in_item_t
//  out     | source    | out_valid_o/out_stall_i | acgm_pkg::out_item_t
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A clip or read item passes accept, store read and write back in turn.
// A begin or clear item skips write back, as it needs none. The mix store
// has one read and one write port, and the read-modify-write of a clip frame
// finishes before the next item is taken.
// After reset a clearing pass writes zero to all MIX_FRAMES entries, one per
// cycle; no item is accepted until that pass is done.
// A read result waits in the output register; a further read item holds in
// write back while that register is still full and stalled.
// ----------------------------------------------------------------------------
module audio_clip_gain_mixer_top #(
  parameter int MIX_FRAMES = acgm_pkg::MixFramesDef,
  parameter int ACC_WIDTH  = acgm_pkg::AccWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  acgm_pkg::in_item_t            in_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output acgm_pkg::out_item_t           out_data_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acgm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [acgm_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int AW   = $clog2(MIX_FRAMES);
  localparam int MW   = 2 * ACC_WIDTH;
  localparam int SumW = ((ACC_WIDTH > 21) ? ACC_WIDTH : 21) + 1;

  localparam logic [AW-1:0] LastEntry = AW'(MIX_FRAMES - 1);

  localparam logic signed [SumW-1:0] AccMax =
    {{(SumW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SumW-1:0] AccMin = ~AccMax;

  localparam logic signed [ACC_WIDTH-1:0] PcmPosOne = ACC_WIDTH'(32768);
  localparam logic signed [ACC_WIDTH-1:0] PcmNegOne = -PcmPosOne;

  // sequencer states
  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  // product rounded to Q.15, half away from zero
  function automatic logic signed [20:0] round_scale(input logic signed [32:0] p);
    logic [31:0] mag;
    logic [31:0] rnd;
    logic [20:0] res;
    mag = p[32] ? 32'(-p) : 32'(p);
    rnd = mag + 32'd2048;
    res = {1'b0, rnd[31:12]};
    return p[32] ? -res : res;
  endfunction

  // accumulator plus scaled sample, saturating
  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [20:0]          b
  );
    logic signed [SumW-1:0] s;
    s = SumW'(a) + SumW'(b);
    if (s > AccMax) s = AccMax;
    if (s < AccMin) s = AccMin;
    return ACC_WIDTH'(s);
  endfunction

  // accumulator to PCM16: clamp to +-1.0, scale by 32767, round
  function automatic logic signed [15:0] to_pcm(input logic signed [ACC_WIDTH-1:0] a);
    logic signed [ACC_WIDTH-1:0] c;
    logic [16:0]                 mag;
    logic [31:0]                 scl;
    logic [15:0]                 res;
    c = a;
    if (a > PcmPosOne) c = PcmPosOne;
    if (a < PcmNegOne) c = PcmNegOne;
    mag = c[ACC_WIDTH-1] ? 17'(-c) : 17'(c);
    scl = {mag, 15'd0} - 32'(mag) + 32'd16384;
    res = scl[30:15];
    return c[ACC_WIDTH-1] ? -res : res;
  endfunction

  // configuration registers
  logic [15:0]        gain_q;
  logic [14:0]        start_frame_q;
  logic [23:0]        clip_start_q;
  logic signed [24:0] max_frames_q;
  logic [14:0]        total_frames_q;
  logic               mono_q;

  // sequencer and clip state
  logic [1:0]  state_q, state_d;
  logic [AW-1:0] clr_addr_q;
  logic [23:0] count_q;
  logic        past_end_q;

  // item registers
  logic [1:0]         op_q;
  logic signed [15:0] left_q, right_q;
  logic [13:0]        idx_q;
  logic [23:0]        offset_q;
  logic               window_q;
  logic               idx_ok_q;

  // read stage results
  logic                  mix_ok_q;
  logic [AW-1:0]         wr_addr_q;
  logic signed [32:0]    prod_l_q, prod_r_q;

  // output register
  logic                  out_valid_q;
  acgm_pkg::out_item_t   out_data_q;

  // store ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  logic          in_acc, out_free;
  logic [24:0]   entry;
  logic          entry_ok;
  logic signed [ACC_WIDTH-1:0] acc_l, acc_r;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // target entry of a clip frame and its window checks
  assign entry    = {10'd0, start_frame_q} + {1'b0, offset_q};
  assign entry_ok = window_q
                 && (max_frames_q[24] || (offset_q < max_frames_q[23:0]))
                 && (entry < {10'd0, total_frames_q})
                 && (32'(entry) < 32'(MIX_FRAMES));

  assign acc_l = ram_rdata[MW-1:ACC_WIDTH];
  assign acc_r = ram_rdata[ACC_WIDTH-1:0];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q         <= acgm_pkg::GainRst;
      start_frame_q  <= acgm_pkg::StartFrameRst;
      clip_start_q   <= acgm_pkg::ClipStartRst;
      max_frames_q   <= acgm_pkg::MaxFramesRst;
      total_frames_q <= acgm_pkg::TotalFramesRst;
      mono_q         <= acgm_pkg::MonoSourceRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        acgm_pkg::RegGain:        gain_q         <= cfg_data_i[15:0];
        acgm_pkg::RegStartFrame:  start_frame_q  <= cfg_data_i[14:0];
        acgm_pkg::RegClipStart:   clip_start_q   <= cfg_data_i[23:0];
        acgm_pkg::RegMaxFrames:   max_frames_q   <= cfg_data_i;
        acgm_pkg::RegTotalFrames: total_frames_q <= cfg_data_i[14:0];
        acgm_pkg::RegMonoSource:  mono_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (clr_addr_q == LastEntry) state_d = ST_IDLE;
      ST_IDLE: if (in_acc) state_d = ST_RD;
      ST_RD: begin
        if (op_q == acgm_pkg::OpClip || op_q == acgm_pkg::OpRead) state_d = ST_WB;
        else state_d = ST_IDLE;
      end
      ST_WB: begin
        if (op_q != acgm_pkg::OpRead || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(idx_q);
    case (state_q)
      ST_INIT: ram_we = 1'b1;
      ST_RD: begin
        if (op_q == acgm_pkg::OpClear) begin
          ram_we    = idx_ok_q;
          ram_waddr = AW'(idx_q);
        end
        if (op_q == acgm_pkg::OpClip) begin
          ram_re    = 1'b1;
          ram_raddr = entry[AW-1:0];
        end
        if (op_q == acgm_pkg::OpRead) begin
          ram_re = 1'b1;
        end
      end
      ST_WB: begin
        if (op_q == acgm_pkg::OpClip) begin
          ram_we    = mix_ok_q;
          ram_waddr = wr_addr_q;
          ram_wdata = {sat_add(acc_l, round_scale(prod_l_q)),
                       sat_add(acc_r, round_scale(prod_r_q))};
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_addr_q  <= '0;
      count_q     <= '0;
      past_end_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      // source frame count
      if (state_q == ST_RD && op_q == acgm_pkg::OpBegin) begin
        count_q    <= '0;
        past_end_q <= 1'b0;
      end else if (state_q == ST_RD && op_q == acgm_pkg::OpClip) begin
        if (count_q == 24'hFFFFFF) past_end_q <= 1'b1;
        else count_q <= count_q + 24'd1;
      end
      // output beat valid
      if (state_q == ST_WB && op_q == acgm_pkg::OpRead && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture, products and output data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_data_i.opcode;
      left_q   <= in_data_i.left_sample;
      right_q  <= mono_q ? in_data_i.left_sample : in_data_i.right_sample;
      idx_q    <= in_data_i.frame_index;
      idx_ok_q <= (32'(in_data_i.frame_index) < 32'(MIX_FRAMES));
      offset_q <= count_q - clip_start_q;
      window_q <= !past_end_q && (count_q >= clip_start_q);
    end
    if (state_q == ST_RD) begin
      mix_ok_q  <= entry_ok;
      wr_addr_q <= entry[AW-1:0];
      prod_l_q  <= 33'(left_q)  * $signed({1'b0, gain_q});
      prod_r_q  <= 33'(right_q) * $signed({1'b0, gain_q});
    end
    if (state_q == ST_WB && op_q == acgm_pkg::OpRead && out_free) begin
      out_data_q.pcm_left  <= idx_ok_q ? to_pcm(acc_l) : 16'sd0;
      out_data_q.pcm_right <= idx_ok_q ? to_pcm(acc_r) : 16'sd0;
    end
  end

  // mix store, left and right accumulators side by side
  acgm_ram #(
    .WIDTH (MW),
    .DEPTH (MIX_FRAMES)
  ) u_mix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // a read beat taken with the output free shows its result after store read and write back, from the output register
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == acgm_pkg::OpRead && !out_valid_o) |=> ##2 out_valid_o)
    else $error("read result not delivered on time");

  // write back of a read never touches the store
  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB && op_q == acgm_pkg::OpRead) |-> !ram_we)
    else $error("store written during a read");

  // the count is pinned at its top once past the end
  a_past_end_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    past_end_q |-> (count_q == 24'hFFFFFF))
    else $error("past end flag set below top count");

  // no new result loaded over a stalled one
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("output beat lost under stall");

endmodule
